FILE: src/edd_pkg.sv
// Shared types and constants for the error diffusion dither core.
package edd_pkg;

  localparam int ERR_W     = 16;   // signed error / accumulator width
  localparam int SAMPLE_W  = 8;
  localparam int CFG_W     = 11;   // line_length register width
  localparam int CFG_RESET = 1024; // line_length after reset
  localparam int NUM_CH    = 3;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [NUM_CH-1:0][ERR_W-1:0] err3_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
    logic                frame_start;
  } pix_in_t;

  typedef struct packed {
    logic red_bit;
    logic green_bit;
    logic blue_bit;
  } pix_out_t;

  // Per-channel operands for one pixel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    err_t                carry;   // error carried along the line
    err_t                above;   // error stored by the previous line
    err_t                pbl;     // pending below-left
    err_t                pb;      // pending below
  } chan_in_t;

  // Per-channel results for one pixel.
  typedef struct packed {
    logic bit_out;
    err_t carry;       // 7/16 share for the next pixel
    err_t below_left;  // completed entry for position - 1
    err_t pbl;         // pending below-left for the next pixel
    err_t pb;          // 1/16 share, pending below for the next pixel
  } chan_res_t;

endpackage

FILE: src/edd_chan.sv
// One color channel: threshold, quantization error and Floyd-Steinberg shares.
module edd_chan import edd_pkg::*; (
  input  chan_in_t  ci,
  output chan_res_t co
);

  localparam logic signed [16:0] ONE_LEVEL  = 17'sd4080;
  localparam logic signed [15:0] HALF_LEVEL = 16'sd2040;

  function automatic err_t sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  logic signed [17:0] sum;
  err_t               val;
  logic               bit_w;
  logic signed [16:0] err;
  logic signed [19:0] err_ext;
  logic signed [19:0] e7;
  logic signed [19:0] e5;
  logic signed [19:0] e3;
  logic signed [19:0] s7;
  logic signed [19:0] s5;
  logic signed [19:0] s3;
  logic signed [19:0] s1;
  logic signed [17:0] bl_sum;
  logic signed [17:0] pbl_sum;

  always_comb begin
    sum = $signed({6'b0, ci.sample, 4'b0})
        + {{2{ci.carry[ERR_W-1]}}, ci.carry}
        + {{2{ci.above[ERR_W-1]}}, ci.above};
    val   = sat16(sum);
    bit_w = val > HALF_LEVEL;
    err   = {val[ERR_W-1], val} - (bit_w ? ONE_LEVEL : 17'sd0);

    // shift-add multiples, then floor divide by 16
    err_ext = {{3{err[16]}}, err};
    e7 = (err_ext <<< 3) - err_ext;
    e5 = (err_ext <<< 2) + err_ext;
    e3 = (err_ext <<< 1) + err_ext;
    s7 = e7 >>> 4;
    s5 = e5 >>> 4;
    s3 = e3 >>> 4;
    s1 = err_ext >>> 4;

    bl_sum  = {{2{ci.pbl[ERR_W-1]}}, ci.pbl} + s3[17:0];
    pbl_sum = {{2{ci.pb[ERR_W-1]}}, ci.pb} + s5[17:0];

    co.bit_out    = bit_w;
    co.carry      = s7[ERR_W-1:0];
    co.below_left = sat16(bl_sum);
    co.pbl        = sat16(pbl_sum);
    co.pb         = s1[ERR_W-1:0];
  end

endmodule

FILE: src/error_diffusion_dither_core.sv
// Top level: Floyd-Steinberg error diffusion dither for an RGB pixel stream.
// Pipeline: input register, then result register, from input transaction to out_valid.
// Throughput: one pixel per cycle while out_stall is low; the line error store is one write
//   port plus one registered read port, with a one-entry deferred write and read bypass
//   covering line ends. Reset (rst_n low, synchronous): clears control and line state, then
//   a clearing pass zeroes all LINE_MAX store entries, one per cycle, with in_stall held high.
module error_diffusion_dither_core import edd_pkg::*; #(
  parameter int LINE_MAX = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pix_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pix_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int LW = $clog2(LINE_MAX);
  localparam logic [LW-1:0] POS_LAST = LW'(LINE_MAX - 1);
  localparam logic [LW-1:0] LAST_RST =
    LW'(((LINE_MAX < CFG_RESET) ? LINE_MAX : CFG_RESET) - 1);

  // ---------------------------------------------------------------------------
  // Line error store: three signed 16-bit errors per position.
  // ---------------------------------------------------------------------------
  err3_t   mem [LINE_MAX];
  err3_t   mem_rd_r;
  logic    wen;
  logic [LW-1:0] waddr;
  err3_t   wdata;
  logic [LW-1:0] raddr;

  // Clearing pass after reset
  logic          clr_busy_r;
  logic [LW-1:0] clr_cnt_r;

  // Configuration: last position index derived from line_length
  logic [LW-1:0] lastidx_r;
  logic [31:0]   cfg_ext;
  logic [LW-1:0] lastidx_nxt;

  // Input register stage
  logic          v1_r;
  pix_in_t       in_r;
  logic [LW-1:0] ra_r;     // store address read for the held pixel
  logic          byp_v_r;  // held pixel's entry was rewritten after the read
  err3_t         byp_d_r;

  // Line state
  err3_t         carry_r;
  err3_t         pbl_r;
  err3_t         pb_r;
  logic [LW-1:0] pos_r;
  logic          first_r;

  // Deferred write of the last position's entry
  logic          dw_v_r;
  logic [LW-1:0] dw_a_r;
  err3_t         dw_d_r;

  // Result register
  logic          out_v_r;
  pix_out_t      out_r;

  logic          acc;
  logic          fire;
  logic          fs;
  logic          first_eff;
  logic [LW-1:0] pos;
  logic          last;
  logic [LW-1:0] pos_after;
  err3_t         above;
  logic [NUM_CH-1:0] bits;
  chan_in_t      ci [NUM_CH];
  chan_res_t     co [NUM_CH];
  err3_t         bl_w;
  err3_t         pbl_new;
  err3_t         carry_nxt;
  err3_t         pbl_nxt;
  err3_t         pb_nxt;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign fire      = v1_r && (!out_v_r || !out_stall);
  assign in_stall  = clr_busy_r || (v1_r && !fire);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // Per-pixel datapath
  // ---------------------------------------------------------------------------
  assign fs        = in_r.frame_start;
  assign first_eff = fs || first_r;
  assign pos       = fs ? '0 : pos_r;
  assign last      = pos >= lastidx_r;
  assign pos_after = last ? '0 : pos + LW'(1);
  assign above     = byp_v_r ? byp_d_r : mem_rd_r;

  // Read address for a pixel entering the input register: its line position
  // once the pixel ahead (if it completes this cycle) has updated the state.
  assign raddr = fire ? pos_after : pos_r;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    always_comb begin
      case (c)
        0:       ci[c].sample = in_r.red_in;
        1:       ci[c].sample = in_r.green_in;
        default: ci[c].sample = in_r.blue_in;
      endcase
      ci[c].carry = fs ? '0 : carry_r[c];
      ci[c].above = first_eff ? '0 : above[c];
      ci[c].pbl   = fs ? '0 : pbl_r[c];
      ci[c].pb    = fs ? '0 : pb_r[c];
    end

    edd_chan u_chan (
      .ci (ci[c]),
      .co (co[c])
    );

    assign bits[c]      = co[c].bit_out;
    assign bl_w[c]      = co[c].below_left;
    assign pbl_new[c]   = co[c].pbl;
    assign carry_nxt[c] = last ? '0 : co[c].carry;
    assign pbl_nxt[c]   = last ? '0 : co[c].pbl;
    assign pb_nxt[c]    = last ? '0 : co[c].pb;
  end

  // ---------------------------------------------------------------------------
  // Store write port. A line end with position > 0 needs two entries; the
  // entry for the last position is held in dw_* and written in the next cycle.
  // ---------------------------------------------------------------------------
  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    if (clr_busy_r) begin
      wen   = 1'b1;
      waddr = clr_cnt_r;
    end else if (fire && (pos != '0)) begin
      wen   = 1'b1;
      waddr = pos - LW'(1);
      wdata = bl_w;
    end else if (fire && last) begin
      wen   = 1'b1;
      waddr = pos;
      wdata = pbl_new;
    end else if (dw_v_r) begin
      wen   = 1'b1;
      waddr = dw_a_r;
      wdata = dw_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mem_rd_r <= mem[raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_ext = 32'(cfg_wdata);

  always_comb begin
    if (cfg_ext == 32'd0) begin
      lastidx_nxt = '0;
    end else if (cfg_ext > 32'(LINE_MAX)) begin
      lastidx_nxt = POS_LAST;
    end else begin
      lastidx_nxt = LW'(cfg_ext - 32'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      lastidx_r  <= LAST_RST;
      v1_r       <= 1'b0;
      byp_v_r    <= 1'b0;
      carry_r    <= '0;
      pbl_r      <= '0;
      pb_r       <= '0;
      pos_r      <= '0;
      first_r    <= 1'b1;
      dw_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + LW'(1);
        if (clr_cnt_r == POS_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end

      if (cfg_we) begin
        lastidx_r <= lastidx_nxt;
      end

      // input register and bypass of entries rewritten after the read
      if (acc) begin
        v1_r    <= 1'b1;
        byp_v_r <= wen && (waddr == raddr);
      end else begin
        if (fire) begin
          v1_r <= 1'b0;
        end
        if (v1_r && !fire && wen && (waddr == ra_r)) begin
          byp_v_r <= 1'b1;
        end
      end

      // line state update when the pixel completes
      if (fire) begin
        carry_r <= carry_nxt;
        pbl_r   <= pbl_nxt;
        pb_r    <= pb_nxt;
        pos_r   <= pos_after;
        first_r <= last ? 1'b0 : first_eff;
      end

      dw_v_r <= fire && last && (pos != '0);

      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      in_r <= in_data;
      ra_r <= raddr;
    end
    if (acc && wen && (waddr == raddr)) begin
      byp_d_r <= wdata;
    end else if (!acc && v1_r && !fire && wen && (waddr == ra_r)) begin
      byp_d_r <= wdata;
    end
    if (fire) begin
      dw_a_r <= pos;
      dw_d_r <= pbl_new;
      out_r  <= '{red_bit: bits[0], green_bit: bits[1], blue_bit: bits[2]};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && out_v_r && out_stall) |-> in_stall)
    else $error("input taken while held pixel cannot complete");

  a_line_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last) |=> (pos_r == '0))
    else $error("line position not reset after line end");

  a_deferred_drains: assert property (@(posedge clk) disable iff (!rst_n)
    dw_v_r |=> !dw_v_r)
    else $error("deferred store write pending for more than one cycle");

  a_bypass_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !fire && wen && (waddr == ra_r)) |=> byp_v_r)
    else $error("rewrite of held pixel's entry not captured");

endmodule
